FILE: rtl/mbp_pkg.sv
// mbp_pkg: byte classes, queue entry and result types for the midi word packer
// no dependencies
`timescale 1ns / 1ps

package mbp_pkg;

  localparam logic [7:0] STATUS_SOX  = 8'hF0;
  localparam logic [7:0] STATUS_SPP  = 8'hF2;
  localparam logic [7:0] STATUS_SSEL = 8'hF3;
  localparam logic [7:0] STATUS_EOX  = 8'hF7;
  localparam logic [7:0] STATUS_BIT  = 8'h80;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;
  localparam logic [3:0] HI_PROG     = 4'hC;
  localparam logic [3:0] HI_PRESS    = 4'hD;

  localparam logic [1:0] KIND_MSG        = 2'd0;
  localparam logic [1:0] KIND_INCOMPLETE = 2'd1;
  localparam logic [1:0] KIND_STRAY      = 2'd2;

  typedef enum logic [2:0] {
    CLS_DATA,
    CLS_NEED1,
    CLS_NEED2,
    CLS_EOX,
    CLS_SOX,
    CLS_SINGLE
  } byte_cls_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    byte_cls_t  cls;
    logic       chan;
  } item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  kind;
  } result_t;

endpackage

FILE: rtl/mbp_fifo.sv
// mbp_fifo: small register queue used between front and back and at the output
// no dependencies
`timescale 1ns / 1ps

module mbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/mbp_front.sv
// mbp_front: classifies each midi byte as data, sox, eox or by the data bytes it asks for
// depends on mbp_pkg
`timescale 1ns / 1ps

module mbp_front (
  input  logic          [7:0] in_byte,
  input  logic                in_last_of_buffer,
  output mbp_pkg::item_t      item
);

  import mbp_pkg::*;

  logic [3:0] hi;

  assign hi = in_byte[7:4];

  always_comb begin
    item.data = in_byte;
    item.last = in_last_of_buffer;
    item.chan = 1'b0;
    if ((in_byte & STATUS_BIT) == '0) begin
      item.cls = CLS_DATA;
    end else if (hi != HI_SYSTEM) begin
      item.chan = 1'b1;
      item.cls  = (hi == HI_PROG || hi == HI_PRESS) ? CLS_NEED1 : CLS_NEED2;
    end else if (in_byte == STATUS_SPP) begin
      item.cls = CLS_NEED2;
    end else if (in_byte == STATUS_SSEL) begin
      item.cls = CLS_NEED1;
    end else if (in_byte == STATUS_EOX) begin
      item.cls = CLS_EOX;
    end else if (in_byte == STATUS_SOX) begin
      item.cls = CLS_SOX;
    end else begin
      item.cls = CLS_SINGLE;
    end
  end

endmodule

FILE: rtl/mbp_back.sv
// mbp_back: running status, sysex and message assembly on classified bytes
// depends on mbp_pkg
`timescale 1ns / 1ps

module mbp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbp_pkg::item_t       item,
  input  logic                 item_valid,
  output logic                 item_take,
  input  logic                 res_full,
  output logic                 res_push,
  output mbp_pkg::result_t     res
);

  import mbp_pkg::*;

  logic [31:0] aw_r, aw_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic        sysex_r, sysex_nxt;
  logic        discard_r, discard_nxt;
  logic        fire;
  logic [31:0] byte_w;
  logic [31:0] aw_or;
  logic [3:0]  rs_hi;

  assign fire      = item_valid && !res_full;
  assign item_take = fire;
  assign byte_w    = {24'b0, item.data};
  assign aw_or     = aw_r | (byte_w << {slot_r, 3'b000});
  assign rs_hi     = rs_r[7:4];

  always_comb begin
    aw_nxt      = aw_r;
    slot_nxt    = slot_r;
    need_nxt    = need_r;
    rs_nxt      = rs_r;
    sysex_nxt   = sysex_r;
    discard_nxt = discard_r;
    res_push    = 1'b0;
    res.word    = byte_w;
    res.kind    = KIND_MSG;
    if (fire) begin
      if (discard_r) begin
        // rest of buffer ignored
      end else if (need_r != '0) begin
        aw_nxt   = aw_or;
        slot_nxt = slot_r + 2'd1;
        need_nxt = need_r - 2'd1;
        if (need_r == 2'd1) begin
          res_push = 1'b1;
          res.word = aw_or;
          aw_nxt   = '0;
          slot_nxt = '0;
        end else if (item.last) begin
          res_push = 1'b1;
          res.word = {24'b0, aw_or[7:0]};
          res.kind = KIND_INCOMPLETE;
        end
      end else if (item.cls != CLS_DATA) begin
        unique case (item.cls)
          CLS_NEED1, CLS_NEED2: begin
            sysex_nxt = 1'b0;
            aw_nxt    = byte_w;
            slot_nxt  = 2'd1;
            need_nxt  = (item.cls == CLS_NEED1) ? 2'd1 : 2'd2;
            if (item.chan) begin
              rs_nxt = item.data;
            end
            if (item.last) begin
              res_push = 1'b1;
              res.kind = KIND_INCOMPLETE;
            end
          end
          CLS_EOX: begin
            res_push  = 1'b1;
            res.word  = sysex_r ? aw_or : byte_w;
            sysex_nxt = 1'b0;
            aw_nxt    = '0;
            slot_nxt  = '0;
          end
          CLS_SOX: begin
            rs_nxt    = '0;
            sysex_nxt = 1'b1;
            aw_nxt    = byte_w;
            slot_nxt  = 2'd1;
          end
          CLS_SINGLE: begin
            res_push  = 1'b1;
            sysex_nxt = 1'b0;
            aw_nxt    = '0;
            slot_nxt  = '0;
          end
          default: begin
          end
        endcase
      end else if (sysex_r) begin
        aw_nxt = aw_or;
        if (slot_r == 2'd3) begin
          res_push = 1'b1;
          res.word = aw_or;
          aw_nxt   = '0;
          slot_nxt = '0;
        end else begin
          slot_nxt = slot_r + 2'd1;
        end
      end else if (rs_r != '0) begin
        if (rs_hi == HI_PROG || rs_hi == HI_PRESS) begin
          res_push = 1'b1;
          res.word = {16'b0, item.data, rs_r};
        end else begin
          aw_nxt   = {16'b0, item.data, rs_r};
          slot_nxt = 2'd2;
          need_nxt = 2'd1;
          if (item.last) begin
            res_push = 1'b1;
            res.word = {24'b0, rs_r};
            res.kind = KIND_INCOMPLETE;
          end
        end
      end else begin
        res_push    = 1'b1;
        res.kind    = KIND_STRAY;
        discard_nxt = 1'b1;
      end
      if (item.last) begin
        aw_nxt      = '0;
        slot_nxt    = '0;
        need_nxt    = '0;
        rs_nxt      = '0;
        sysex_nxt   = 1'b0;
        discard_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r      <= '0;
      slot_r    <= '0;
      need_r    <= '0;
      rs_r      <= '0;
      sysex_r   <= 1'b0;
      discard_r <= 1'b0;
    end else begin
      aw_r      <= aw_nxt;
      slot_r    <= slot_nxt;
      need_r    <= need_nxt;
      rs_r      <= rs_nxt;
      sysex_r   <= sysex_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule

FILE: rtl/midi_byte_stream_to_word_packer.sv
// midi_byte_stream_to_word_packer: top level, classifier, byte queue, parser, word queue
// depends on mbp_pkg, mbp_front, mbp_fifo, mbp_back
//
//   channel  | ports                                      | handshake
//   input    | in_byte, in_last_of_buffer                 | push / full
//   result   | out_packed_word, out_result_kind           | empty / pop
//
// one byte per cycle sustained while the word queue has room; a word enters it at
// the edge its byte leaves the byte queue; it is then read out from the word queue register
// the parser loop (assembly word, slot, running status) sets the one-byte-per-cycle rate
// synchronous reset clears both queues and all parser state
// full rises when the byte queue holds QUEUE_DEPTH bytes; the parser stalls while
// the word queue is full
`timescale 1ns / 1ps

module midi_byte_stream_to_word_packer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic        in_last_of_buffer,
  input  logic        push,
  output logic        full,
  output logic [31:0] out_packed_word,
  output logic [1:0]  out_result_kind,
  output logic        empty,
  input  logic        pop
);

  import mbp_pkg::*;

  item_t   front_item;
  item_t   back_item;
  logic    mid_empty;
  logic    item_take;
  logic    res_full;
  logic    res_push;
  result_t back_res;
  result_t out_res;

  mbp_front u_front (
    .in_byte           (in_byte),
    .in_last_of_buffer (in_last_of_buffer),
    .item              (front_item)
  );

  mbp_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_byte_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_item),
    .full    (full),
    .pop     (item_take),
    .rd_data (back_item),
    .empty   (mid_empty)
  );

  mbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (back_item),
    .item_valid (!mid_empty),
    .item_take  (item_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res)
  );

  mbp_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_word_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

  assign out_packed_word = out_res.word;
  assign out_result_kind = out_res.kind;

endmodule

FILE: verif/tb_midi_byte_stream_to_word_packer.sv
// tb_midi_byte_stream_to_word_packer: self-checking bench for the midi byte to word packer
// depends on mbp_pkg and midi_byte_stream_to_word_packer; directed table, then random buffers
// each word is compared with a typed table row or a packer model; random gaps on both queues
`timescale 1ns / 1ps

module tb_midi_byte_stream_to_word_packer;
  import mbp_pkg::*;

  localparam int BYTE_TARGET = 1050;
  localparam int CALM_TAIL   = 150;
  localparam int DRAIN_WAIT  = 16;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    logic [7:0]  b;
    logic        last;
    bit          typed;
    logic [31:0] word;
    logic [1:0]  kind;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last_of_buffer = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] out_packed_word;
  logic [1:0]  out_result_kind;
  logic        empty;
  logic        pop = 1'b0;

  // packer model state
  logic [31:0] asm_word;
  logic [1:0]  slot;
  logic [1:0]  need;
  logic [7:0]  run_status;
  logic        sysex;
  logic        dropping;

  result_t words_due[$];
  int      err_count = 0;
  int      cycles = 0;
  int      fed_count = 0;
  int      rx_hold = 0;
  bit      rx_gaps = 1'b1;
  bit      tx_gaps = 1'b1;
  bit      calm = 1'b0;

  plan_row_t plan[26] = '{
    '{8'h90, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h3C, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h7F, 1'b0, 1'b1, 32'h007F3C90, KIND_MSG},
    '{8'h00, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h7F, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'hC5, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h12, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h13, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'hF8, 1'b0, 1'b1, 32'h000000F8, KIND_MSG},
    '{8'hF0, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h01, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h02, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h03, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'hF7, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'hF7, 1'b0, 1'b1, 32'h000000F7, KIND_MSG},
    '{8'hF3, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h05, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'hF2, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'hF0, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h80, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'hE0, 1'b0, 1'b0, 32'h0, KIND_MSG},
    '{8'h00, 1'b1, 1'b1, 32'h000000E0, KIND_INCOMPLETE},
    '{8'h45, 1'b0, 1'b1, 32'h00000045, KIND_STRAY},
    '{8'hF2, 1'b1, 1'b0, 32'h0, KIND_MSG},
    '{8'hFF, 1'b1, 1'b1, 32'h000000FF, KIND_MSG},
    '{8'hB0, 1'b1, 1'b1, 32'h000000B0, KIND_INCOMPLETE}
  };

  midi_byte_stream_to_word_packer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_byte           (in_byte),
    .in_last_of_buffer (in_last_of_buffer),
    .push              (push),
    .full              (full),
    .out_packed_word   (out_packed_word),
    .out_result_kind   (out_result_kind),
    .empty             (empty),
    .pop               (pop)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
  endtask

  function automatic void start_msg(input logic [7:0] b, input logic [1:0] cnt);
    sysex = 1'b0;
    asm_word = {24'd0, b};
    slot = 2'd1;
    need = cnt;
  endfunction

  function automatic void clear_packer();
    asm_word = '0;
    slot = '0;
    need = '0;
    run_status = '0;
    sysex = 1'b0;
    dropping = 1'b0;
  endfunction

  // returns 1 when the byte produces a result word
  function automatic bit pack_midi_byte(input logic [7:0] b, input logic last,
                                        output result_t res);
    bit          hit;
    logic [31:0] w;
    hit = 1'b0;
    res = '0;
    if (dropping) begin
    end else if (need != 2'd0) begin
      asm_word = asm_word | (32'(b) << (8 * slot));
      slot = slot + 2'd1;
      need = need - 2'd1;
      if (need == 2'd0) begin
        hit = 1'b1;
        res = '{word: asm_word, kind: KIND_MSG};
        asm_word = '0;
        slot = '0;
      end else if (last) begin
        hit = 1'b1;
        res = '{word: {24'd0, asm_word[7:0]}, kind: KIND_INCOMPLETE};
      end
    end else if (b[7]) begin
      if (b[7:4] == HI_PROG || b[7:4] == HI_PRESS) begin
        start_msg(b, 2'd1);
        run_status = b;
      end else if (b[7:4] != HI_SYSTEM) begin
        start_msg(b, 2'd2);
        run_status = b;
      end else if (b == STATUS_SPP) begin
        start_msg(b, 2'd2);
      end else if (b == STATUS_SSEL) begin
        start_msg(b, 2'd1);
      end else if (b == STATUS_EOX) begin
        w = sysex ? (asm_word | (32'(STATUS_EOX) << (8 * slot))) : 32'(STATUS_EOX);
        hit = 1'b1;
        res = '{word: w, kind: KIND_MSG};
        sysex = 1'b0;
        asm_word = '0;
        slot = '0;
      end else if (b[3:0] != 4'h0) begin
        sysex = 1'b0;
        asm_word = '0;
        slot = '0;
        hit = 1'b1;
        res = '{word: 32'(b), kind: KIND_MSG};
      end else begin
        run_status = '0;
        sysex = 1'b1;
        asm_word = 32'(STATUS_SOX);
        slot = 2'd1;
      end
      if (need != 2'd0 && last) begin
        hit = 1'b1;
        res = '{word: 32'(b), kind: KIND_INCOMPLETE};
      end
    end else if (sysex) begin
      asm_word = asm_word | (32'(b) << (8 * slot));
      if (slot == 2'd3) begin
        hit = 1'b1;
        res = '{word: asm_word, kind: KIND_MSG};
        asm_word = '0;
        slot = '0;
      end else begin
        slot = slot + 2'd1;
      end
    end else if (run_status != 8'h00) begin
      if (run_status[7:4] == HI_PROG || run_status[7:4] == HI_PRESS) begin
        hit = 1'b1;
        res = '{word: {16'd0, b, run_status}, kind: KIND_MSG};
      end else begin
        asm_word = {16'd0, b, run_status};
        slot = 2'd2;
        need = 2'd1;
        if (last) begin
          hit = 1'b1;
          res = '{word: 32'(run_status), kind: KIND_INCOMPLETE};
        end
      end
    end else begin
      hit = 1'b1;
      res = '{word: 32'(b), kind: KIND_STRAY};
      dropping = 1'b1;
    end
    if (last) clear_packer();
    return hit;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input result_t typed_res);
    result_t res;
    bit      got;
    if (!calm && tx_gaps && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_last_of_buffer <= last;
    do @(posedge clk); while (full);
    fed_count++;
    got = pack_midi_byte(b, last, res);
    if (typed) words_due.push_back(typed_res);
    else if (got) words_due.push_back(res);
  endtask

  function automatic logic [7:0] pick_channel_status();
    logic [3:0] hi;
    hi = 4'($urandom_range(8, 14));
    return {hi, 4'($urandom_range(0, 15))};
  endfunction

  function automatic int data_count(input logic [7:0] status);
    return (status[7:4] == HI_PROG || status[7:4] == HI_PRESS) ? 1 : 2;
  endfunction

  task automatic send_random_message();
    logic [7:0] seq[$];
    logic [7:0] st;
    int         sel;
    int         n;
    sel = $urandom_range(0, 19);
    if (sel < 8) begin
      st = pick_channel_status();
      seq.push_back(st);
      repeat (data_count(st)) seq.push_back(8'($urandom_range(0, 127)));
      repeat ($urandom_range(0, 3) * data_count(st)) seq.push_back(8'($urandom_range(0, 127)));
    end else if (sel == 8) begin
      seq = '{STATUS_SPP, 8'($urandom_range(0, 127)), 8'($urandom_range(0, 127))};
    end else if (sel == 9) begin
      seq = '{STATUS_SSEL, 8'($urandom_range(0, 127))};
    end else if (sel < 12) begin
      st = 8'($urandom_range(241, 255));
      while (st == STATUS_SPP || st == STATUS_SSEL || st == STATUS_EOX)
        st = 8'($urandom_range(241, 255));
      seq.push_back(st);
    end else if (sel < 16) begin
      seq.push_back(STATUS_SOX);
      n = $urandom_range(0, 10);
      repeat (n) seq.push_back(8'($urandom_range(0, 127)));
      if ($urandom_range(0, 6) != 0) begin
        seq.push_back(STATUS_EOX);
      end else begin
        st = pick_channel_status();
        seq.push_back(st);
        repeat (data_count(st)) seq.push_back(8'($urandom_range(0, 127)));
      end
    end else if (sel == 16) begin
      seq.push_back(STATUS_EOX);
    end else if (sel == 17) begin
      seq.push_back(8'($urandom_range(0, 127)));
    end else begin
      repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[i]) send_byte(seq[i], $urandom_range(0, 29) == 0, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    result_t due;
    if (rst_n && pop && !empty) begin
      if (words_due.size() == 0) begin
        report_mismatch("word with nothing due", out_packed_word, '0);
      end else begin
        due = words_due.pop_front();
        if (out_packed_word !== due.word)
          report_mismatch("packed word", out_packed_word, due.word);
        if (out_result_kind !== due.kind)
          report_mismatch("result kind", 32'(out_result_kind), 32'(due.kind));
      end
    end
    if (rx_hold > 0) begin
      pop <= 1'b0;
      rx_hold--;
    end else if (!calm && rx_gaps && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      rx_hold = $urandom_range(0, 13);
    end else begin
      pop <= 1'b1;
    end
    if (!calm && $urandom_range(0, 79) == 0) rx_gaps = !rx_gaps;
  end

  initial begin
    result_t row_res;
    clear_packer();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) begin
      row_res = '{word: plan[i].word, kind: plan[i].kind};
      send_byte(plan[i].b, plan[i].last, plan[i].typed, row_res);
    end
    while (fed_count < BYTE_TARGET) begin
      if (fed_count > BYTE_TARGET - CALM_TAIL) calm = 1'b1;
      if ($urandom_range(0, 15) == 0) tx_gaps = !tx_gaps;
      send_random_message();
    end
    push <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: midi_byte_stream_to_word_packer.f
rtl/mbp_pkg.sv
rtl/mbp_fifo.sv
rtl/mbp_front.sv
rtl/mbp_back.sv
rtl/midi_byte_stream_to_word_packer.sv
verif/tb_midi_byte_stream_to_word_packer.sv
